/* hdl/cable_wear_range_histogram_assert.svh */
// Assertion macros for the RTL files; cwrh_seq.sv includes them.
`ifndef CABLE_WEAR_RANGE_HISTOGRAM_ASSERT_SVH
`define CABLE_WEAR_RANGE_HISTOGRAM_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is active.
`define CWRH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CWRH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CWRH_ASSERT(label, clk, rst_n, prop, msg)
`define CWRH_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* hdl/cwrh_pkg.sv */
package cwrh_pkg;

    localparam int SEGMENTS   = 4096;
    localparam int NUM_CABLES = 8;
    localparam int NUM_BENDS  = 5;

    localparam int SEG_W  = $clog2(SEGMENTS);
    localparam int POS_W  = SEG_W + 1;
    localparam int DEPTH  = NUM_CABLES * SEGMENTS;
    localparam int ADDR_W = $clog2(DEPTH);

    // field widths
    localparam int LEN_W    = 12;
    localparam int CABLE_W  = 3;
    localparam int OFF_W    = 11;
    localparam int BCNT_W   = 3;
    localparam int WEAR_W   = 16;
    localparam int CIDX_W   = 3;
    localparam int DIFF_W   = (SEG_W + 2 > LEN_W + 2) ? SEG_W + 2 : LEN_W + 2;

    typedef logic [LEN_W-1:0]         len_t;
    typedef logic [CABLE_W-1:0]       cable_t;
    typedef logic signed [OFF_W-1:0]  offset_t;
    typedef logic [BCNT_W-1:0]        bcnt_t;
    typedef logic [WEAR_W-1:0]        wear_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CIDX_W-1:0]        cfg_index_t;

    localparam wear_t WEAR_MAX = '1;

    // transaction modes
    localparam logic MODE_ANALYZE = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    // configuration register indexes
    localparam cfg_index_t CFG_OFFSET_A   = 3'd0;
    localparam cfg_index_t CFG_OFFSET_B   = 3'd1;
    localparam cfg_index_t CFG_OFFSET_C   = 3'd2;
    localparam cfg_index_t CFG_OFFSET_D   = 3'd3;
    localparam cfg_index_t CFG_OFFSET_E   = 3'd4;
    localparam cfg_index_t CFG_BEND_COUNT = 3'd5;

    localparam offset_t OFFSET_RESET [NUM_BENDS] = '{
        11'sd20, 11'sd0, -11'sd200, -11'sd230, -11'sd400
    };
    localparam bcnt_t BEND_COUNT_RESET = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BEND_LO,
        ST_BEND_HI,
        ST_RD,
        ST_WR,
        ST_RDQ,
        ST_RDQ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t addr;
        wear_t wdata;
    } mem_req_t;

endpackage

/* hdl/cwrh_if.sv */
interface cwrh_item_if;
    import cwrh_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    cable_t cable_index;
    len_t   start_length;
    len_t   end_length;
    len_t   segment_index;

    modport source (output valid, mode, cable_index, start_length, end_length,
                    segment_index, input ready);
    modport sink   (input valid, mode, cable_index, start_length, end_length,
                    segment_index, output ready);
endinterface

interface cwrh_result_if;
    import cwrh_pkg::*;

    logic  valid;
    logic  ready;
    logic  applied;
    wear_t wear_count;

    modport source (output valid, applied, wear_count, input ready);
    modport sink   (input valid, applied, wear_count, output ready);
endinterface

/* hdl/cwrh_store.sv */
module cwrh_store (
    input  logic               clk,
    input  cwrh_pkg::mem_req_t req,
    output cwrh_pkg::wear_t    rdata
);
    import cwrh_pkg::*;

    wear_t mem [DEPTH];
    wear_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/cwrh_clamp.sv */
module cwrh_clamp (
    input  cwrh_pkg::len_t    len,
    input  cwrh_pkg::offset_t off,
    output cwrh_pkg::pos_t    pos
);
    import cwrh_pkg::*;

    logic signed [DIFF_W-1:0] diff;

    // len - offset, clamped to [0, SEGMENTS]
    assign diff = $signed({{(DIFF_W-LEN_W){1'b0}}, len}) - DIFF_W'(off);

    always_comb
    begin
        priority if (diff < 0)
        begin
            pos = '0;
        end
        else if (diff > $signed(DIFF_W'(SEGMENTS)))
        begin
            pos = POS_W'(SEGMENTS);
        end
        else
        begin
            pos = diff[POS_W-1:0];
        end
    end

endmodule

/* hdl/cwrh_seq.sv */
`include "cable_wear_range_histogram_assert.svh"

module cwrh_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  cwrh_pkg::offset_t   offsets [cwrh_pkg::NUM_BENDS],
    input  cwrh_pkg::bcnt_t     bend_count,
    cwrh_item_if.sink           item,
    cwrh_result_if.source       result,
    output cwrh_pkg::mem_req_t  mem_req,
    input  cwrh_pkg::wear_t     mem_rdata
);
    import cwrh_pkg::*;

    state_t   state_reg, state_next;
    addr_t    clr_cnt_reg;
    addr_t    base_reg;
    len_t     lo_len_reg, hi_len_reg, seg_reg;
    bcnt_t    bidx_reg, nb_reg;
    pos_t     j_reg, hi_reg;
    logic     applied_reg;
    wear_t    wear_reg;
    logic     out_valid_reg, out_applied_reg;
    wear_t    out_wear_reg;

    logic     accept, cab_ok, seg_ok, len_eq, out_free, last_bend, j_more;
    bcnt_t    nb_in;
    len_t     unit_len;
    pos_t     unit_pos;
    wear_t    wear_inc;

    // shared subtract-and-clamp unit: low end, then high end of each bend
    assign unit_len = (state_reg == ST_BEND_LO) ? lo_len_reg : hi_len_reg;

    cwrh_clamp u_clamp (
        .len (unit_len),
        .off (offsets[bidx_reg]),
        .pos (unit_pos)
    );

    assign accept    = item.valid && item.ready;
    assign cab_ok    = 32'(item.cable_index) < 32'(NUM_CABLES);
    assign seg_ok    = 32'(item.segment_index) < 32'(SEGMENTS);
    assign len_eq    = item.start_length == item.end_length;
    assign nb_in     = (bend_count > BCNT_W'(NUM_BENDS)) ? BCNT_W'(NUM_BENDS) : bend_count;
    assign out_free  = !out_valid_reg || result.ready;
    assign last_bend = (bidx_reg + 1'b1) == nb_reg;
    assign j_more    = (j_reg + 1'b1) < hi_reg;
    assign wear_inc  = (mem_rdata == WEAR_MAX) ? mem_rdata : mem_rdata + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    priority if (!cab_ok)
                        state_next = ST_DONE;
                    else if (item.mode == MODE_READ)
                        state_next = seg_ok ? ST_RDQ : ST_DONE;
                    else if (len_eq || nb_in == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_BEND_LO;
                end
            end
            ST_BEND_LO:
            begin
                state_next = ST_BEND_HI;
            end
            ST_BEND_HI:
            begin
                priority if (j_reg < unit_pos)
                    state_next = ST_RD;
                else if (last_bend)
                    state_next = ST_DONE;
                else
                    state_next = ST_BEND_LO;
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                priority if (j_more)
                    state_next = ST_RD;
                else if (last_bend)
                    state_next = ST_DONE;
                else
                    state_next = ST_BEND_LO;
            end
            ST_RDQ:
            begin
                state_next = ST_RDQ_WAIT;
            end
            ST_RDQ_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        item.ready    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = base_reg + ADDR_W'(j_reg[SEG_W-1:0]);
        mem_req.wdata = wear_inc;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_cnt_reg;
                mem_req.wdata = '0;
            end
            ST_IDLE:
            begin
                item.ready = 1'b1;
            end
            ST_WR:
            begin
                mem_req.we = 1'b1;
            end
            ST_RDQ, ST_RDQ_WAIT:
            begin
                mem_req.addr = base_reg + ADDR_W'(seg_reg);
            end
            ST_BEND_LO, ST_BEND_HI, ST_RD, ST_DONE:
            begin
                mem_req.we = 1'b0;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and walk pointers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg    <= ADDR_W'(item.cable_index) * ADDR_W'(SEGMENTS);
            lo_len_reg  <= (item.start_length < item.end_length) ? item.start_length
                                                                 : item.end_length;
            hi_len_reg  <= (item.start_length < item.end_length) ? item.end_length
                                                                 : item.start_length;
            seg_reg     <= item.segment_index;
            bidx_reg    <= '0;
            nb_reg      <= nb_in;
            applied_reg <= cab_ok && ((item.mode == MODE_READ) ? seg_ok : !len_eq);
            wear_reg    <= '0;
        end
        if (state_reg == ST_BEND_LO)
        begin
            j_reg <= unit_pos;
        end
        if (state_reg == ST_BEND_HI)
        begin
            hi_reg <= unit_pos;
        end
        if (state_reg == ST_WR)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if ((state_reg == ST_BEND_HI || state_reg == ST_WR) && state_next == ST_BEND_LO)
        begin
            bidx_reg <= bidx_reg + 1'b1;
        end
        if (state_reg == ST_RDQ_WAIT)
        begin
            wear_reg <= mem_rdata;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_applied_reg <= applied_reg;
            out_wear_reg    <= wear_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.applied    = out_applied_reg;
    assign result.wear_count = out_wear_reg;

    `CWRH_ASSERT(a_rmw_same_addr, clk, rst_n, (state_reg == ST_WR) |-> (mem_req.addr == $past(mem_req.addr)), "read-modify-write address moved")
    `CWRH_ASSERT(a_walk_in_range, clk, rst_n, (state_reg == ST_RD) |-> (j_reg < hi_reg), "counter walk past range end")
    `CWRH_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE), "result without finished item")
    `CWRH_ASSERT_ALWAYS(a_no_take_in_clear, clk, (state_reg == ST_CLEAR) |-> !item.ready, "item taken while store clears")

endmodule

/* hdl/cable_wear_range_histogram.sv */
// Read transaction: ST_RDQ and ST_RDQ_WAIT read the counter, and the result is
// registered out of ST_DONE once the result slot is free. Analyze transaction:
// ST_BEND_LO and ST_BEND_HI clamp each active bend's range, then the single-port
// store gets one read-modify-write per counter touched (ST_RD, ST_WR); equal lengths
// or no bends in use skip to ST_DONE. Reset (rst_n, async low) restores the bend
// registers, then clears NUM_CABLES * SEGMENTS = 32768 counters one per cycle.
module cable_wear_range_histogram (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  cwrh_pkg::cfg_index_t cfg_index,
    input  cwrh_pkg::offset_t    cfg_data,
    cwrh_item_if.sink            item,
    cwrh_result_if.source        result
);
    import cwrh_pkg::*;

    // shared bend offsets and count: user writes them only while idle, not enforced
    offset_t  offset_reg [NUM_BENDS];
    bcnt_t    bend_count_reg;

    // store port between sequencer and counter memory
    mem_req_t mem_req;
    wear_t    mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= OFFSET_RESET;
            bend_count_reg <= BEND_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_A:   offset_reg[0]  <= cfg_data;
                CFG_OFFSET_B:   offset_reg[1]  <= cfg_data;
                CFG_OFFSET_C:   offset_reg[2]  <= cfg_data;
                CFG_OFFSET_D:   offset_reg[3]  <= cfg_data;
                CFG_OFFSET_E:   offset_reg[4]  <= cfg_data;
                CFG_BEND_COUNT: bend_count_reg <= cfg_data[BCNT_W-1:0];
                // indexes past the list are ignored
                default:        bend_count_reg <= bend_count_reg;
            endcase
        end
    end

    // sequencer: walks each bend's clamped range, one counter per RMW pair
    cwrh_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .offsets    (offset_reg),
        .bend_count (bend_count_reg),
        .item       (item),
        .result     (result),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    // wear counters, NUM_CABLES x SEGMENTS, registered read
    cwrh_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

// Testbench for cable_wear_range_histogram.
// Items go through a driver fed from a queue. Each accepted item is applied to
// a local copy of the wear store, and that step yields the expected response.
// A monitor checks each response against the oldest expected one.
module testbench;
    import cwrh_pkg::*;

    // one pending request with the idle gap the driver inserts before it
    typedef struct {
        logic        mode;
        cable_t      cable_index;
        len_t        start_length;
        len_t        end_length;
        len_t        segment_index;
        int unsigned gap;
    } motion_request_t;

    typedef struct {
        logic  applied;
        wear_t wear_count;
    } wear_outcome_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    offset_t    cfg_data;

    cwrh_item_if   item_bus ();
    cwrh_result_if result_bus ();

    cable_wear_range_histogram uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (result_bus)
    );

    // local copy of the block state and its bend settings
    wear_t   wear_model [DEPTH];
    offset_t offset_model [NUM_BENDS];
    bcnt_t   bend_count_model;

    motion_request_t motion_requests [$];
    wear_outcome_t   wear_predictions [$];
    motion_request_t in_flight;

    int unsigned send_idle;
    int unsigned recv_wait;
    bit          calm_phase;

    // generator hint: last analyzed region, so reads land on touched counters
    int hot_cable;
    int hot_low;
    int hot_span;

    int error_count;
    int analyze_count;
    int read_count;
    int nonzero_reads;
    int setting_count;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int clamp_segment(input int v);
        if (v < 0)
            return 0;
        if (v > SEGMENTS)
            return SEGMENTS;
        return v;
    endfunction

    // Applies one transaction to the wear copy and returns the response it must give.
    function automatic wear_outcome_t apply_to_wear_model(input motion_request_t req);
        wear_outcome_t r;
        int            base;
        int            lo_len;
        int            hi_len;
        int            lo;
        int            hi;
        int            n;
        int            b;
        int            j;
        r.applied    = 1'b0;
        r.wear_count = '0;
        if (int'(req.cable_index) < NUM_CABLES)
        begin
            base = int'(req.cable_index) * SEGMENTS;
            if (req.mode == MODE_READ)
            begin
                if (int'(req.segment_index) < SEGMENTS)
                begin
                    r.wear_count = wear_model[base + int'(req.segment_index)];
                    r.applied    = 1'b1;
                end
            end
            else if (req.start_length != req.end_length)
            begin
                lo_len = (req.start_length < req.end_length) ? int'(req.start_length)
                                                             : int'(req.end_length);
                hi_len = (req.start_length < req.end_length) ? int'(req.end_length)
                                                             : int'(req.start_length);
                // counts above the number of bends use all of them
                n = (int'(bend_count_model) > NUM_BENDS) ? NUM_BENDS : int'(bend_count_model);
                for (b = 0; b < n; b++)
                begin
                    lo = clamp_segment(lo_len - int'(offset_model[b]));
                    hi = clamp_segment(hi_len - int'(offset_model[b]));
                    for (j = lo; j < hi; j++)
                    begin
                        // counters saturate
                        if (wear_model[base + j] != WEAR_MAX)
                            wear_model[base + j] = wear_model[base + j] + 1'b1;
                    end
                end
                r.applied = 1'b1;
            end
        end
        return r;
    endfunction

    // Driver: presents queued requests after their idle gap, predicts on accept.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
            send_idle      <= 0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                wear_predictions = {wear_predictions, apply_to_wear_model(in_flight)};
                if (in_flight.mode == MODE_READ)
                    read_count++;
                else
                    analyze_count++;
            end
            if (!item_bus.valid || item_bus.ready)
            begin
                if (motion_requests.size() != 0 && send_idle >= motion_requests[0].gap)
                begin
                    in_flight = motion_requests.pop_front();
                    item_bus.valid         <= 1'b1;
                    item_bus.mode          <= in_flight.mode;
                    item_bus.cable_index   <= in_flight.cable_index;
                    item_bus.start_length  <= in_flight.start_length;
                    item_bus.end_length    <= in_flight.end_length;
                    item_bus.segment_index <= in_flight.segment_index;
                    send_idle              <= 0;
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                    if (motion_requests.size() != 0)
                        send_idle <= send_idle + 1;
                end
            end
        end
    end

    // Monitor: checks each response, then may hold ready low for a random stall (never in the calm phase).
    always @(posedge clk)
    begin
        wear_outcome_t exp_out;
        int unsigned   stall;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            recv_wait        <= 0;
        end
        else if (result_bus.valid && result_bus.ready)
        begin
            if (wear_predictions.size() == 0)
            begin
                $display("%0t: unexpected response, expected none actual applied %0d wear %0d",
                         $time, result_bus.applied, result_bus.wear_count);
                error_count++;
            end
            else
            begin
                exp_out = wear_predictions.pop_front();
                if (result_bus.applied !== exp_out.applied)
                begin
                    $display("%0t: applied mismatch, expected %0d actual %0d",
                             $time, exp_out.applied, result_bus.applied);
                    error_count++;
                end
                if (result_bus.wear_count !== exp_out.wear_count)
                begin
                    $display("%0t: wear_count mismatch, expected %0d actual %0d",
                             $time, exp_out.wear_count, result_bus.wear_count);
                    error_count++;
                end
                if (exp_out.wear_count != 0)
                    nonzero_reads++;
            end
            stall = calm_phase ? 0 : $urandom_range(0, 14);
            if (stall == 0)
                result_bus.ready <= 1'b1;
            else
            begin
                result_bus.ready <= 1'b0;
                recv_wait        <= stall;
            end
        end
        else if (!result_bus.ready)
        begin
            if (recv_wait > 1)
                recv_wait <= recv_wait - 1;
            else
            begin
                recv_wait        <= 0;
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic push_request(input logic mode, input int cable, input int start_len,
                                input int end_len, input int seg);
        motion_request_t r;
        r.mode          = mode;
        r.cable_index   = cable_t'(cable);
        r.start_length  = len_t'(start_len);
        r.end_length    = len_t'(end_len);
        r.segment_index = len_t'(seg);
        r.gap           = calm_phase ? 0 : $urandom_range(0, 14);
        motion_requests = {motion_requests, r};
    endtask

    // Mostly analyze with short ranges, and reads aimed at the last touched region.
    task automatic push_random_request();
        int unsigned pick;
        int unsigned size_pick;
        int          span;
        int          start_len;
        int          seg;
        int          b;
        pick      = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            if (size_pick < 6)
                span = 0;
            else if (size_pick < 8)
                span = $urandom_range(513, 4095);
            else if (size_pick < 14)
                span = $urandom_range(49, 512);
            else
                span = $urandom_range(1, 48);
            start_len = $urandom_range(0, 4095 - span);
            hot_cable = $urandom_range(0, NUM_CABLES - 1);
            hot_low   = start_len;
            hot_span  = span;
            if ($urandom_range(0, 1))
                push_request(MODE_ANALYZE, hot_cable, start_len, start_len + span,
                             $urandom_range(0, 4095));
            else
                push_request(MODE_ANALYZE, hot_cable, start_len + span, start_len,
                             $urandom_range(0, 4095));
        end
        else if (pick < 85)
        begin
            b   = $urandom_range(0, NUM_BENDS - 1);
            seg = hot_low - int'(offset_model[b]) + int'($urandom_range(0, hot_span));
            seg = (seg < 0) ? 0 : (seg > SEGMENTS - 1) ? SEGMENTS - 1 : seg;
            push_request(MODE_READ, hot_cable, $urandom_range(0, 4095),
                         $urandom_range(0, 4095), seg);
        end
        else
            push_request(MODE_READ, $urandom_range(0, NUM_CABLES - 1), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    task automatic write_register(input cfg_index_t idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= offset_t'(value);
        if (idx == CFG_BEND_COUNT)
            bend_count_model = bcnt_t'(value);
        else
            offset_model[idx] = offset_t'(value);
    endtask

    // Only called with the block idle.
    task automatic program_bends(input int off_a, input int off_b, input int off_c,
                                 input int off_d, input int off_e, input int count);
        write_register(CFG_OFFSET_A, off_a);
        write_register(CFG_OFFSET_B, off_b);
        write_register(CFG_OFFSET_C, off_c);
        write_register(CFG_OFFSET_D, off_d);
        write_register(CFG_OFFSET_E, off_e);
        write_register(CFG_BEND_COUNT, count);
        @(posedge clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Idle once nothing is queued, nothing is on the bus and every response has come.
    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (motion_requests.size() != 0 || item_bus.valid || wear_predictions.size() != 0);
    endtask

    function automatic int draw_offset();
        if ($urandom_range(0, 1))
            return int'($urandom_range(0, 600)) - 300;
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    initial
    begin
        int i;
        int phase;
        int k;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_OFFSET_A;
        cfg_data               = '0;
        item_bus.valid         = 1'b0;
        item_bus.mode          = MODE_ANALYZE;
        item_bus.cable_index   = '0;
        item_bus.start_length  = '0;
        item_bus.end_length    = '0;
        item_bus.segment_index = '0;
        result_bus.ready       = 1'b0;
        error_count   = 0;
        analyze_count = 0;
        read_count    = 0;
        nonzero_reads = 0;
        setting_count = 1;
        calm_phase    = 1'b0;
        hot_cable     = 0;
        hot_low       = 0;
        hot_span      = 0;
        send_idle     = 0;
        recv_wait     = 0;
        for (i = 0; i < DEPTH; i++)
            wear_model[i] = '0;
        for (i = 0; i < NUM_BENDS; i++)
            offset_model[i] = OFFSET_RESET[i];
        bend_count_model = BEND_COUNT_RESET;

        // Reset settings: store cleared, ascending and descending moves, equal
        // lengths, a full-length move, and a move clamped at the top of the store.
        push_request(MODE_READ, 0, 0, 0, 0);
        push_request(MODE_ANALYZE, 0, 100, 110, 4095);
        push_request(MODE_ANALYZE, 0, 110, 100, 0);
        push_request(MODE_ANALYZE, 0, 500, 500, 0);
        push_request(MODE_READ, 0, 4095, 0, 85);
        push_request(MODE_READ, 0, 0, 4095, 305);
        push_request(MODE_READ, 0, 0, 0, 509);
        push_request(MODE_READ, 0, 0, 0, 510);
        push_request(MODE_ANALYZE, 7, 0, 4095, 0);
        push_request(MODE_ANALYZE, 3, 4095, 3500, 0);
        push_request(MODE_READ, 7, 0, 0, 4095);
        push_request(MODE_READ, 3, 0, 0, 4095);
        push_request(MODE_READ, 7, 0, 0, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_for_idle();

        // Extreme offsets: ranges pushed fully below zero and fully past the end.
        program_bends(1023, -1024, 0, 511, -512, 5);
        push_request(MODE_ANALYZE, 1, 0, 10, 0);
        push_request(MODE_ANALYZE, 1, 4095, 4090, 0);
        push_request(MODE_READ, 1, 0, 0, 1024);
        push_request(MODE_READ, 1, 0, 0, 3070);
        push_request(MODE_READ, 1, 0, 0, 0);
        push_request(MODE_READ, 1, 0, 0, 4094);
        wait_for_idle();

        // No bends in use: still applied, nothing counted.
        program_bends(0, 0, 0, 0, 0, 0);
        push_request(MODE_ANALYZE, 2, 5, 9, 0);
        push_request(MODE_READ, 2, 0, 0, 5);
        wait_for_idle();

        // Count above five with all offsets equal: one counter gains five.
        program_bends(0, 0, 0, 0, 0, 7);
        push_request(MODE_ANALYZE, 4, 10, 11, 0);
        push_request(MODE_READ, 4, 0, 0, 10);
        wait_for_idle();

        // Random phases, each with its own bend setting; one runs without gaps.
        for (phase = 0; phase < 5; phase++)
        begin
            program_bends(draw_offset(), draw_offset(), draw_offset(), draw_offset(),
                          draw_offset(), $urandom_range(0, 7));
            calm_phase = (phase == 2);
            for (k = 0; k < 53; k++)
                push_random_request();
            wait_for_idle();
        end

        // room for any stray response
        repeat (32) @(posedge clk);
        if (wear_predictions.size() != 0)
            error_count++;
        $display("Ran %0d analyze and %0d read transactions under %0d bend settings.",
                 analyze_count, read_count, setting_count);
        $display("%0d responses carried a nonzero count; %0d mismatches seen.",
                 nonzero_reads, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // The expected run is mostly the store clear and a few full-length moves; this
    // watchdog ends a hung run with FAIL.
    initial
    begin
        #24_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* cable_wear_range_histogram.f */
+incdir+hdl
hdl/cwrh_pkg.sv
hdl/cwrh_if.sv
hdl/cwrh_store.sv
hdl/cwrh_clamp.sv
hdl/cwrh_seq.sv
hdl/cable_wear_range_histogram.sv
verif/testbench.sv
